### rtl/qrpcd_pkg.sv
// ============================================================================
// qrpcd_pkg
// Shared types and constants for the quaternion roll/pitch move detector.
// ============================================================================
package qrpcd_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int AngTableLen = 24;
    localparam int ThreshWidth = 15;
    localparam logic [ThreshWidth-1:0] ThreshReset = 15'd819;

    // Working widths: t terms fit in 34 bits, CORDIC vectors grow by about 1.65x.
    localparam int TWidth = 34;
    localparam int VWidth = 37;
    localparam int ZWidth = 20;
    localparam int SqWidth = 58;

    localparam logic signed [ZWidth-1:0] HalfPiZ = 20'sd102944;
    localparam logic signed [15:0] PiQ13 = 16'sd25736;
    localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
    localparam logic signed [TWidth-1:0] OneQ28 = 34'sd268435456;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sqrt_start;
        logic cordic_start;
        logic sel_pitch;
        logic store_roll;
        logic store_pitch;
        logic finish;
    } qrpcd_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic cordic_done;
    } qrpcd_stat_t;

    function automatic logic [ZWidth-1:0] atan_entry(input logic [4:0] idx);
        logic [ZWidth-1:0] v;
        begin
            case (idx)
                5'd0: v = 20'd51472;
                5'd1: v = 20'd30386;
                5'd2: v = 20'd16055;
                5'd3: v = 20'd8150;
                5'd4: v = 20'd4091;
                5'd5: v = 20'd2047;
                5'd6: v = 20'd1024;
                5'd7: v = 20'd512;
                5'd8: v = 20'd256;
                5'd9: v = 20'd128;
                5'd10: v = 20'd64;
                5'd11: v = 20'd32;
                5'd12: v = 20'd16;
                5'd13: v = 20'd8;
                5'd14: v = 20'd4;
                5'd15: v = 20'd2;
                5'd16: v = 20'd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

### rtl/qrpcd_ctrl.sv
// ============================================================================
// qrpcd_ctrl
// Sequencer that steps the datapath through products, square root and the
// two CORDIC passes for one transaction.
// ============================================================================
module qrpcd_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_fire,
    input  logic                    in_pose_valid,
    input  logic                    out_free,
    input  qrpcd_pkg::qrpcd_stat_t  stat,
    output logic                    busy,
    output qrpcd_pkg::qrpcd_cmd_t   cmd
);
    import qrpcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_CLAMP, S_SQRT, S_ROLL_GO, S_ROLL,
        S_PITCH_GO, S_PITCH, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = in_pose_valid ? S_MUL0 : S_OUT;
                end
            end
            S_MUL0:
            begin
                cmd.mul_step = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_step = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_step = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.sqrt_start = 1'b1;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = S_ROLL_GO;
                end
            end
            S_ROLL_GO:
            begin
                cmd.cordic_start = 1'b1;
                state_next = S_ROLL;
            end
            S_ROLL:
            begin
                if (stat.cordic_done)
                begin
                    cmd.store_roll = 1'b1;
                    state_next = S_PITCH_GO;
                end
            end
            S_PITCH_GO:
            begin
                cmd.cordic_start = 1'b1;
                cmd.sel_pitch = 1'b1;
                state_next = S_PITCH;
            end
            S_PITCH:
            begin
                cmd.sel_pitch = 1'b1;
                if (stat.cordic_done)
                begin
                    cmd.store_pitch = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_fire) else $error("transaction accepted while busy");
    a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free) else $error("result finished into full output");
    a_store_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_pitch |-> !cmd.store_roll) else $error("both stores at once");
`endif

endmodule

### rtl/qrpcd_datapath.sv
// ============================================================================
// qrpcd_datapath
// Products, clamp, bit-serial square root, shared CORDIC vectoring unit and
// step/compare logic.
// ============================================================================
module qrpcd_datapath
#(
    parameter int CORDIC_STEPS = qrpcd_pkg::CordicStepsDefault
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  qrpcd_pkg::qrpcd_cmd_t       cmd,
    input  logic                        in_pose_valid,
    input  logic signed [15:0]          in_x,
    input  logic signed [15:0]          in_y,
    input  logic signed [15:0]          in_z,
    input  logic signed [15:0]          in_w,
    input  logic [qrpcd_pkg::ThreshWidth-1:0] threshold,
    output qrpcd_pkg::qrpcd_stat_t      stat,
    output logic                        res_flag,
    output logic signed [16:0]          res_roll_step,
    output logic signed [15:0]          res_pitch_step
);
    import qrpcd_pkg::*;

    localparam int CntW = $clog2(CORDIC_STEPS + 1);

    logic                     pv_reg;
    logic signed [15:0]       qx_reg, qy_reg, qz_reg, qw_reg;
    logic [1:0]               mstep_reg;
    logic signed [TWidth-1:0] t0_reg, t1_reg, t2_reg;
    logic [SqWidth-1:0]       sq_n_reg;
    logic [SqWidth-1:0]       sq_r_reg;
    logic [5:0]               sq_cnt_reg;
    logic                     sq_busy_reg;
    logic signed [VWidth-1:0] cx_reg, cy_reg;
    logic signed [ZWidth-1:0] cz_reg;
    logic [CntW-1:0]          ci_reg;
    logic                     c_busy_reg;
    logic signed [15:0]       roll_reg, pitch_reg;
    logic signed [15:0]       last_roll_reg;
    logic signed [14:0]       last_pitch_reg;

    logic signed [31:0] p0, p1;
    logic signed [TWidth-1:0] t2c;
    logic [28:0] t2m;
    logic [SqWidth-1:0] t2sq;
    logic [SqWidth-1:0] sq_trial;
    logic signed [VWidth-1:0] sx, sy, dx, dy;
    logic signed [ZWidth-1:0] z0, zr;
    logic signed [ZWidth-4:0] zq;
    logic signed [15:0] lim, sat;
    logic [4:0] tab_idx;
    logic signed [16:0] rs;
    logic signed [15:0] ps;

    // Two multipliers, reused for the t0, t1 and t2 product pairs.
    always_comb
    begin
        case (mstep_reg)
            2'd0:
            begin
                p0 = qw_reg * qx_reg;
                p1 = qy_reg * qz_reg;
            end
            2'd1:
            begin
                p0 = qx_reg * qx_reg;
                p1 = qy_reg * qy_reg;
            end
            default:
            begin
                p0 = qw_reg * qy_reg;
                p1 = qz_reg * qx_reg;
            end
        endcase
    end

    always_comb
    begin
        if (t2_reg > OneQ28)
        begin
            t2c = OneQ28;
        end
        else if (t2_reg < -OneQ28)
        begin
            t2c = -OneQ28;
        end
        else
        begin
            t2c = t2_reg;
        end
    end

    assign t2m = t2c[TWidth-1] ? 29'(-t2c) : 29'(t2c);
    assign t2sq = SqWidth'(t2m) * SqWidth'(t2m);

    assign sq_trial = sq_r_reg + (58'd1 << {sq_cnt_reg[4:0], 1'b0});

    // CORDIC start vector.
    always_comb
    begin
        if (cmd.sel_pitch)
        begin
            sx = VWidth'(sq_r_reg);
            sy = VWidth'(t2_reg);
        end
        else
        begin
            sx = VWidth'(t1_reg);
            sy = VWidth'(t0_reg);
        end
        z0 = '0;
        if (sx < 0)
        begin
            if (sy >= 0)
            begin
                z0 = HalfPiZ;
                dx = sy;
                dy = -sx;
            end
            else
            begin
                z0 = -HalfPiZ;
                dx = -sy;
                dy = sx;
            end
        end
        else
        begin
            dx = sx;
            dy = sy;
        end
    end

    assign tab_idx = 5'(ci_reg);
    assign zr = (cz_reg + ZWidth'(4)) >>> 3;
    assign zq = zr[ZWidth-4:0];
    assign lim = cmd.sel_pitch ? HalfPiQ13 : PiQ13;

    always_comb
    begin
        if (zq > lim)
        begin
            sat = lim;
        end
        else if (zq < -lim)
        begin
            sat = -lim;
        end
        else
        begin
            sat = 16'(zq);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= '0;
            t0_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
            sq_n_reg <= '0;
            sq_r_reg <= '0;
            sq_cnt_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            ci_reg <= '0;
            roll_reg <= '0;
            pitch_reg <= '0;
            sq_busy_reg <= 1'b0;
            c_busy_reg <= 1'b0;
            mstep_reg <= '0;
            last_roll_reg <= '0;
            last_pitch_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                pv_reg <= in_pose_valid;
                qx_reg <= in_x;
                qy_reg <= in_y;
                qz_reg <= in_z;
                qw_reg <= in_w;
                mstep_reg <= '0;
            end
            if (cmd.mul_step)
            begin
                mstep_reg <= mstep_reg + 2'd1;
                case (mstep_reg)
                    2'd0: t0_reg <= TWidth'(33'(p0) + 33'(p1)) <<< 1;
                    2'd1: t1_reg <= OneQ28 - (TWidth'(33'(p0) + 33'(p1)) <<< 1);
                    default: t2_reg <= TWidth'(33'(p0) - 33'(p1)) <<< 1;
                endcase
            end
            if (cmd.sqrt_start)
            begin
                t2_reg <= t2c;
                sq_n_reg <= (58'd1 << 56) - t2sq;
                sq_r_reg <= '0;
                sq_cnt_reg <= 6'd28;
                sq_busy_reg <= 1'b1;
            end
            else if (sq_busy_reg)
            begin
                if (sq_n_reg >= sq_trial)
                begin
                    sq_n_reg <= sq_n_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + (58'd1 << {sq_cnt_reg[4:0], 1'b0});
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                if (sq_cnt_reg == 6'd0)
                begin
                    sq_busy_reg <= 1'b0;
                end
                else
                begin
                    sq_cnt_reg <= sq_cnt_reg - 6'd1;
                end
            end
            if (cmd.cordic_start)
            begin
                cx_reg <= dx;
                cy_reg <= dy;
                cz_reg <= (sx == 0 && sy == 0) ? '0 : z0;
                ci_reg <= (sx == 0 && sy == 0) ? CntW'(CORDIC_STEPS) : '0;
                c_busy_reg <= 1'b1;
            end
            else if (c_busy_reg)
            begin
                if (ci_reg == CntW'(CORDIC_STEPS))
                begin
                    c_busy_reg <= 1'b0;
                end
                else
                begin
                    ci_reg <= ci_reg + CntW'(1);
                    if (cy_reg >= 0)
                    begin
                        cx_reg <= cx_reg + (cy_reg >>> ci_reg);
                        cy_reg <= cy_reg - (cx_reg >>> ci_reg);
                        cz_reg <= cz_reg + ZWidth'(atan_entry(tab_idx));
                    end
                    else
                    begin
                        cx_reg <= cx_reg - (cy_reg >>> ci_reg);
                        cy_reg <= cy_reg + (cx_reg >>> ci_reg);
                        cz_reg <= cz_reg - ZWidth'(atan_entry(tab_idx));
                    end
                end
            end
            if (cmd.store_roll)
            begin
                roll_reg <= sat;
            end
            if (cmd.store_pitch)
            begin
                pitch_reg <= sat;
            end
            if (cmd.finish && pv_reg)
            begin
                last_roll_reg <= roll_reg;
                last_pitch_reg <= 15'(pitch_reg);
            end
        end
    end

    assign stat.sqrt_done = !sq_busy_reg;
    assign stat.cordic_done = c_busy_reg && (ci_reg == CntW'(CORDIC_STEPS));

    assign rs = 17'(last_roll_reg) - 17'(roll_reg);
    assign ps = 16'(last_pitch_reg) - pitch_reg;
    assign res_roll_step = pv_reg ? rs : '0;
    assign res_pitch_step = pv_reg ? ps : '0;
    assign res_flag = pv_reg && ((rs > $signed({2'b00, threshold}))
                      || (ps > $signed({1'b0, threshold})));

`ifndef ASSERT_OFF
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        sq_busy_reg |-> !c_busy_reg) else $error("sqrt and cordic overlap");
    a_ci_range: assert property (@(posedge clk) disable iff (!rst_n)
        c_busy_reg |-> ci_reg <= CntW'(CORDIC_STEPS)) else $error("cordic count");
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.store_pitch) |-> (pitch_reg <= HalfPiQ13 && pitch_reg >= -HalfPiQ13))
        else $error("pitch out of range");
`endif

endmodule

### rtl/quat_to_roll_pitch_change_detect_core.sv
// A transaction is accepted only when the core is idle; an invalid pose goes straight to the output.
// A new transaction is not accepted until the previous result is handed to the output; a held result stalls the next.
// The transaction time is set by the 29-step square root and the two passes of the shared CORDIC.
// Reset (rst_n, asynchronous, active low) clears stored angles and loads threshold 819.
// ============================================================================
// quat_to_roll_pitch_change_detect_core
// Head orientation quaternion to roll/pitch steps with a move flag.
// ============================================================================
module quat_to_roll_pitch_change_detect_core
#(
    parameter int CORDIC_STEPS = qrpcd_pkg::CordicStepsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    input  logic        s_axis_tuser,   // pose_valid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // roll_step, pitch_step, zero pad
    output logic        m_axis_tuser,   // move_flag
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data        // move_threshold
);
    import qrpcd_pkg::*;

    qrpcd_cmd_t  cmd;
    qrpcd_stat_t stat;
    logic busy, in_fire, out_free, flag;
    logic signed [16:0] rstep;
    logic signed [15:0] pstep;
    logic [ThreshWidth-1:0] thresh_reg;
    logic [32:0] out_data_reg;
    logic out_user_reg, out_valid_reg;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    qrpcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_pose_valid(s_axis_tuser),
        .out_free(out_free), .stat(stat), .busy(busy), .cmd(cmd)
    );

    qrpcd_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_pose_valid(s_axis_tuser),
        .in_x(s_axis_tdata[15:0]), .in_y(s_axis_tdata[31:16]),
        .in_z(s_axis_tdata[47:32]), .in_w(s_axis_tdata[63:48]),
        .threshold(thresh_reg), .stat(stat), .res_flag(flag),
        .res_roll_step(rstep), .res_pitch_step(pstep)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= ThreshReset;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_user_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg <= {pstep, rstep};
                out_user_reg <= flag;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_data_reg};
    assign m_axis_tuser = out_user_reg;

endmodule

### dv/tb_quat_to_roll_pitch_change_detect_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_quat_to_roll_pitch_change_detect_core
// Self-checking testbench for the quaternion roll/pitch move detector. A queue
// of pose transactions feeds a clocked driver, and a clocked monitor compares
// each result against a bit-accurate CORDIC predictor of roll/pitch steps.
// ============================================================================
module tb_quat_to_roll_pitch_change_detect_core;

    import qrpcd_pkg::*;

    localparam int Steps = 16;
    localparam longint OneQ28L = 64'sd268435456;

    typedef struct packed {
        logic              valid;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } pose_t;

    typedef struct packed {
        logic               move;
        logic signed [16:0] roll_step;
        logic signed [15:0] pitch_step;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [14:0] cfg_data;

    pose_t pose_q[$];
    step_t step_q[$];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    errors;
    logic [14:0] thresh_m;
    logic signed [15:0] roll_m;
    logic signed [14:0] pitch_m;

    quat_to_roll_pitch_change_detect_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_units(longint y, longint x);
        longint z;
        longint nx;
        longint ny;
        longint dx;
        longint dy;
        longint tab[17];
        tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2, 1};
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y; ny = -x; z = 102944;
            end
            else
            begin
                nx = -y; ny = x; z = -102944;
            end
            x = nx; y = ny;
        end
        for (int i = 0; i < Steps; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += (i < 17) ? tab[i] : 0;
            end
            else
            begin
                x -= dx; y += dy; z -= (i < 17) ? tab[i] : 0;
            end
        end
        return z;
    endfunction

    function automatic longint angle_q13(longint z, longint lim);
        longint a;
        a = shr_floor(z + 4, 3);
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        return a;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        r = longint'($sqrt(real'(n)));
        while (r * r > n) r--;
        while ((r + 1) * (r + 1) <= n) r++;
        return r;
    endfunction

    function automatic step_t predict_steps(pose_t p);
        step_t r;
        longint x, y, z, w, t0, t1, t2, mag, c, roll, pitch, rs, ps;
        r = '0;
        if (!p.valid)
            return r;
        x = p.qx; y = p.qy; z = p.qz; w = p.qw;
        t0 = 2 * (w * x + y * z);
        t1 = OneQ28L - 2 * (x * x + y * y);
        t2 = 2 * (w * y - z * x);
        if (t2 > OneQ28L) t2 = OneQ28L;
        if (t2 < -OneQ28L) t2 = -OneQ28L;
        mag = (t2 < 0) ? -t2 : t2;
        c = root_floor((64'sd1 <<< 56) - mag * mag);
        roll = angle_q13(atan_units(t0, t1), 25736);
        pitch = angle_q13(atan_units(t2, c), 12868);
        rs = longint'(roll_m) - roll;
        ps = longint'(pitch_m) - pitch;
        r.move = (rs > longint'(thresh_m)) || (ps > longint'(thresh_m));
        r.roll_step = rs[16:0];
        r.pitch_step = ps[15:0];
        roll_m = roll[15:0];
        pitch_m = pitch[14:0];
        return r;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic push_pose(logic v, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z, logic [15:0] w);
        pose_t p;
        p.valid = v; p.qx = x; p.qy = y; p.qz = z; p.qw = w;
        pose_q = {pose_q, p};
    endtask

    task automatic drain_then_config(logic [14:0] value);
        while (pose_q.size() != 0 || s_axis_tvalid || step_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        thresh_m = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                step_q = {step_q, predict_steps({s_axis_tuser, s_axis_tdata[15:0],
                                                 s_axis_tdata[31:16], s_axis_tdata[47:32],
                                                 s_axis_tdata[63:48]})};
            if (pose_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                pose_t p;
                p = pose_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= p.valid;
                s_axis_tdata <= {p.qw, p.qz, p.qy, p.qx};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (step_q.size() == 0)
                begin
                    $error("unexpected result tdata=%h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    step_t e;
                    e = step_q.pop_front();
                    if (m_axis_tuser !== e.move)
                    begin
                        $error("move_flag exp %0d got %0d", e.move, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[16:0] !== e.roll_step)
                    begin
                        $error("roll_step exp %0d got %0d", e.roll_step,
                               $signed(m_axis_tdata[16:0]));
                        errors++;
                    end
                    if (m_axis_tdata[32:17] !== e.pitch_step)
                    begin
                        $error("pitch_step exp %0d got %0d", e.pitch_step,
                               $signed(m_axis_tdata[32:17]));
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int wait_cycles;
        logic [15:0] a;
        logic [15:0] b;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        thresh_m = ThreshReset;
        roll_m = '0;
        pitch_m = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, axis rotations, extremes, zero vector, invalid poses.
        push_pose(1, 0, 0, 0, 16384);
        push_pose(1, 16384, 0, 0, 0);
        push_pose(1, 0, 16384, 0, 0);
        push_pose(1, 0, 0, 16384, 0);
        push_pose(1, 11585, 0, 0, 11585);
        push_pose(1, 0, 11585, 0, 11585);
        push_pose(1, 0, -11585, 0, 11585);
        push_pose(1, 11585, 0, 0, 11585);
        push_pose(1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        push_pose(1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_pose(1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        push_pose(1, 11585, 11585, 0, 0);
        push_pose(0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_pose(1, -16384, 0, 0, 16384);
        push_pose(1, 16384, 0, 0, -16384);
        push_pose(0, 0, 0, 0, 0);
        push_pose(1, 0, 0, 0, 0);
        push_pose(1, 16384, 16384, 0, 0);
        push_pose(1, -16384, 0, 0, 1);
        push_pose(1, 0, -16384, 16384, 16384);
        drain_then_config(15'd0);
        push_pose(1, 16384, 0, 0, 0);
        push_pose(1, 0, 0, 0, 16384);
        drain_then_config(15'h7fff);
        push_pose(1, 16384, 0, 0, 0);
        push_pose(1, 0, 0, 0, 16384);

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 74; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 74; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            drain_then_config(ph == 5 ? 15'd25736 : 15'($urandom_range(0, 25736)));
            for (int n = 0; n < 240; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    // Near-identity pose with small x, y, z components to exercise near-threshold steps.
                    a = 16'($urandom_range(0, 4000) - 2000);
                    b = 16'($urandom_range(0, 4000) - 2000);
                    push_pose(1, a, b, 16'($urandom_range(0, 2000) - 1000),
                              16'($urandom_range(15000, 16384)));
                end
                else
                    push_pose($urandom_range(0, 9) != 0, rand_comp(), rand_comp(),
                              rand_comp(), rand_comp());
            end
        end

        while (pose_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        wait_cycles = 0;
        while (step_q.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && step_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
